/* rtl/svs_pkg.sv */
// shared types and constants for the scored victim selector
`timescale 1ns / 1ps
package svs_pkg;

  localparam int GAIN_W  = 24;
  localparam int VISIT_W = 32;
  localparam int STEP_W  = 48;
  localparam int DEC_W   = 16;
  localparam int WIN_W   = 16;
  localparam int IDX_W   = 8;
  localparam int SCORE_W = 48;
  localparam int ROOT_W  = 25;
  localparam int SQ_W    = 50;
  localparam int LOG_W   = 16;
  localparam int BLEN_W  = 6;
  localparam int SQRT_ITERS = 25;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd32;

  // round(1e-4 * b * ln(2) * 2^24) for bit length b
  localparam logic [LOG_W-1:0] LOG_TERM [0:32] = '{
    16'd0,     16'd1163,  16'd2326,  16'd3489,  16'd4652,  16'd5815,  16'd6977,
    16'd8140,  16'd9303,  16'd10466, 16'd11629, 16'd12792, 16'd13955, 16'd15118,
    16'd16281, 16'd17444, 16'd18607, 16'd19769, 16'd20932, 16'd22095, 16'd23258,
    16'd24421, 16'd25584, 16'd26747, 16'd27910, 16'd29073, 16'd30236, 16'd31399,
    16'd32561, 16'd33724, 16'd34887, 16'd36050, 16'd37213
  };

  typedef struct packed {
    logic start;
    logic sqrt_step;
    logic mul;
    logic sum;
    logic commit;
  } svs_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } svs_status_t;

endpackage

/* rtl/svs_ctrl.sv */
// sequencer for one entry: load, square root iterations, multiply, add, compare
`timescale 1ns / 1ps
module svs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  svs_pkg::svs_status_t status,
  output svs_pkg::svs_cmd_t    cmd
);
  import svs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQRT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [4:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          iter_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'(SQRT_ITERS - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!(status.last && status.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/svs_datapath.sv */
// entry registers, square root unit, score, running bests and result register
`timescale 1ns / 1ps
module svs_datapath #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  svs_pkg::svs_cmd_t                 cmd,
  output svs_pkg::svs_status_t              status,
  input  logic                              cfg_wr_en,
  input  logic [svs_pkg::WIN_W-1:0]         cfg_wr_data,
  input  logic signed [svs_pkg::GAIN_W-1:0] in_gain_fixed,
  input  logic [svs_pkg::VISIT_W-1:0]       in_visit_count,
  input  logic [svs_pkg::STEP_W-1:0]        in_updated_at,
  input  logic [svs_pkg::DEC_W-1:0]         in_decision_id,
  input  logic [svs_pkg::STEP_W-1:0]        in_now_step,
  input  logic                              in_last_entry,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [svs_pkg::IDX_W-1:0]         out_victim_index
);
  import svs_pkg::*;

  localparam int POS_W = $clog2(MAX_ENTRIES + 1);

  logic [WIN_W-1:0]   window_r;
  logic [GAIN_W-2:0]  g_r;
  logic [LOG_W-1:0]   lterm_r;
  logic [STEP_W-1:0]  upd_r, now_r;
  logic [DEC_W-1:0]   dec_r;
  logic               last_r;
  logic [SQ_W-1:0]    rem_r, res_r, bit_r;
  logic [SCORE_W-1:0] prod_r, score_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               free_r, free_nxt;
  logic [SCORE_W-1:0] all_score_r, free_score_r;
  logic [STEP_W-1:0]  all_step_r, free_step_r;
  logic [DEC_W-1:0]   all_dec_r, free_dec_r;
  logic [IDX_W-1:0]   all_idx_r, all_idx_nxt, free_idx_r, free_idx_nxt;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;

  logic [BLEN_W-1:0]  blen;
  logic [SQ_W-1:0]    trial;
  logic               in_range, prob, beat_all, beat_free, take_all, take_free;
  logic [STEP_W:0]    age;

  always_comb begin
    blen = '0;
    for (int i = 0; i < VISIT_W; i++) begin
      if (in_visit_count[i]) blen = BLEN_W'(i + 1);
    end
  end

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // entry capture and score arithmetic
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      g_r     <= in_gain_fixed[GAIN_W-1] ? '0 : in_gain_fixed[GAIN_W-2:0];
      lterm_r <= LOG_TERM[blen];
      upd_r   <= in_updated_at;
      now_r   <= in_now_step;
      dec_r   <= in_decision_id;
      last_r  <= in_last_entry;
      rem_r   <= {1'b0, ({1'b0, in_visit_count} + 33'd1), 16'd0};
      res_r   <= '0;
      bit_r   <= SQ_W'(1) << (2 * (SQRT_ITERS - 1));
    end
    if (cmd.sqrt_step) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul) prod_r <= g_r * res_r[ROOT_W-1:0];
    if (cmd.sum) score_r <= prod_r + SCORE_W'(lterm_r);
  end

  assign in_range = pos_r < POS_W'(MAX_ENTRIES);
  assign age      = {1'b0, now_r} - {1'b0, upd_r};
  assign prob     = !age[STEP_W] && (age[STEP_W-1:0] < STEP_W'(window_r));

  always_comb begin
    beat_all = (score_r != all_score_r) ? (score_r < all_score_r) :
               (upd_r != all_step_r)    ? (upd_r < all_step_r) : (dec_r > all_dec_r);
    beat_free = (score_r != free_score_r) ? (score_r < free_score_r) :
                (upd_r != free_step_r)    ? (upd_r < free_step_r) : (dec_r > free_dec_r);
    take_all  = in_range && ((pos_r == '0) || beat_all);
    take_free = in_range && !prob && (!free_r || beat_free);
    all_idx_nxt  = take_all ? IDX_W'(pos_r) : all_idx_r;
    free_idx_nxt = take_free ? IDX_W'(pos_r) : free_idx_r;
    free_nxt = free_r || take_free;
    pos_nxt  = in_range ? pos_r + POS_W'(1) : pos_r;
    if (last_r) begin
      free_nxt = 1'b0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (take_all) begin
        all_score_r <= score_r;
        all_step_r  <= upd_r;
        all_dec_r   <= dec_r;
      end
      if (take_free) begin
        free_score_r <= score_r;
        free_step_r  <= upd_r;
        free_dec_r   <= dec_r;
      end
      all_idx_r  <= all_idx_nxt;
      free_idx_r <= free_idx_nxt;
      if (last_r) out_idx_r <= (free_r || take_free) ? free_idx_nxt : all_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pos_r  <= pos_nxt;
        free_r <= free_nxt;
      end
      if (cmd.commit && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.last     = last_r;
  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_victim_index = out_idx_r;

endmodule

/* rtl/scored_victim_selector.sv */
// top level of the scored victim selector
`timescale 1ns / 1ps
// Each entry of a scan is taken as one transfer and scored as max(gain,0)*sqrt(visits+1)
// plus a small log term; the lowest score not on probation wins (ties: older step, then
// larger decision id), else the lowest overall. The result transfer follows the entry marked
// last. An entry passes a load step, square root iterations taking two radicand bits each,
// then multiply, add and compare steps before in_ready returns. The result waits in an
// output register while the next scan streams in.
module scored_victim_selector #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [svs_pkg::WIN_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [svs_pkg::GAIN_W-1:0] in_gain_fixed,
  input  logic [svs_pkg::VISIT_W-1:0]       in_visit_count,
  input  logic [svs_pkg::STEP_W-1:0]        in_updated_at,
  input  logic [svs_pkg::DEC_W-1:0]         in_decision_id,
  input  logic [svs_pkg::STEP_W-1:0]        in_now_step,
  input  logic                              in_last_entry,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [svs_pkg::IDX_W-1:0]         out_victim_index
);
  import svs_pkg::*;

  svs_cmd_t    cmd;
  svs_status_t status;

  svs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  svs_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_gain_fixed    (in_gain_fixed),
    .in_visit_count   (in_visit_count),
    .in_updated_at    (in_updated_at),
    .in_decision_id   (in_decision_id),
    .in_now_step      (in_now_step),
    .in_last_entry    (in_last_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_victim_index (out_victim_index)
  );

endmodule

/* rtl/svs_checker.sv */
// port-level checks for the scored victim selector, bound to the top level
`timescale 1ns / 1ps
module svs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_entry,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_victim_index
);

  // one entry at a time
  a_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an entry is in progress");

  // only the last entry yields a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_entry && !out_valid |=> !out_valid)
    else $error("result without a last entry");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_index))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind scored_victim_selector svs_checker u_svs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last_entry    (in_last_entry),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_victim_index (out_victim_index)
);

/* test/scored_victim_selector_tb.sv */
// self-checking testbench for the scored victim selector
`timescale 1ns / 1ps
module scored_victim_selector_tb;
  import svs_pkg::*;

  localparam int MAX_ENT = 256;

  class victim_scoreboard;
    logic [WIN_W-1:0] window;
    int unsigned      position;
    bit               free_seen;
    logic [63:0]      all_score, free_score;
    logic [STEP_W-1:0] all_step, free_step;
    logic [DEC_W-1:0] all_dec, free_dec;
    logic [IDX_W-1:0] all_idx, free_idx;
    logic [IDX_W-1:0] victims [$];
    int               mismatches;

    function new();
      window = WINDOW_RESET;
      position = 0;
      free_seen = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] root_of(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] score_of(logic signed [GAIN_W-1:0] gain, logic [VISIT_W-1:0] visits);
      logic [63:0] g;
      logic [63:0] blen;
      logic [63:0] vv;
      g = gain < 0 ? 64'd0 : 64'(gain);
      blen = 0;
      vv = visits;
      while (vv != 0) begin
        blen++;
        vv = vv >> 1;
      end
      return g * root_of((64'(visits) + 1) << 16) + (blen * 64'd1162907997 + 64'd500000)
             / 64'd1000000;
    endfunction

    function bit wins(logic [63:0] s, logic [STEP_W-1:0] st, logic [DEC_W-1:0] d,
                      logic [63:0] bs, logic [STEP_W-1:0] bst, logic [DEC_W-1:0] bd);
      if (s != bs) return s < bs;
      if (st != bst) return st < bst;
      return d > bd;
    endfunction

    function void note_entry(logic signed [GAIN_W-1:0] gain, logic [VISIT_W-1:0] visits,
                             logic [STEP_W-1:0] upd, logic [DEC_W-1:0] dec,
                             logic [STEP_W-1:0] now, logic last);
      logic [63:0] s;
      bit prob;
      if (position < MAX_ENT) begin
        s = score_of(gain, visits);
        prob = (now >= upd) && ((now - upd) < 48'(window));
        if (position == 0 || wins(s, upd, dec, all_score, all_step, all_dec)) begin
          all_score = s; all_step = upd; all_dec = dec; all_idx = position[7:0];
        end
        if (!prob && (!free_seen || wins(s, upd, dec, free_score, free_step, free_dec))) begin
          free_score = s; free_step = upd; free_dec = dec; free_idx = position[7:0];
          free_seen = 1;
        end
        position++;
      end
      if (last) begin
        victims.push_back(free_seen ? free_idx : all_idx);
        position = 0;
        free_seen = 0;
      end
    endfunction

    function void check_victim(logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      if (victims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected victim %0d", got);
        return;
      end
      want = victims.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("victim_index expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_wr_en;
  logic [WIN_W-1:0] cfg_wr_data;
  logic in_valid, in_ready, in_last_entry, out_valid, out_ready;
  logic signed [GAIN_W-1:0] in_gain_fixed;
  logic [VISIT_W-1:0] in_visit_count;
  logic [STEP_W-1:0] in_updated_at, in_now_step;
  logic [DEC_W-1:0] in_decision_id;
  logic [IDX_W-1:0] out_victim_index;

  victim_scoreboard sb;
  int send_idle, recv_idle;
  bit in_done;

  scored_victim_selector i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_gain_fixed(in_gain_fixed),
    .in_visit_count(in_visit_count), .in_updated_at(in_updated_at),
    .in_decision_id(in_decision_id), .in_now_step(in_now_step),
    .in_last_entry(in_last_entry), .out_valid(out_valid), .out_ready(out_ready),
    .out_victim_index(out_victim_index)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: ready changes at the falling edge, transfer sampled at the rising edge
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_victim(out_victim_index);
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_entry(logic signed [GAIN_W-1:0] g, logic [VISIT_W-1:0] v,
                            logic [STEP_W-1:0] u, logic [DEC_W-1:0] d,
                            logic [STEP_W-1:0] n, logic l);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    in_gain_fixed <= g; in_visit_count <= v; in_updated_at <= u;
    in_decision_id <= d; in_now_step <= n; in_last_entry <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_entry(g, v, u, d, n, l);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.victims.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] w);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.window = w;
  endtask

  function automatic logic [VISIT_W-1:0] rand_visits();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // one random scan; small gain/visit pools make ties common
  task automatic random_scan(int len);
    logic [STEP_W-1:0] now, u;
    logic signed [GAIN_W-1:0] g;
    now = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    if ($urandom_range(3) == 0) now = $urandom_range(100);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) now = {$urandom, $urandom};
      case ($urandom_range(3))
        0: u = now - $urandom_range(64);
        1: u = now + $urandom_range(3);
        2: u = {$urandom, $urandom};
        default: u = now - ($urandom_range(3) * 16);
      endcase
      g = $urandom_range(3) == 0 ? GAIN_W'($urandom_range(2) - 1) : GAIN_W'($urandom);
      send_entry(g, $urandom_range(1) ? 32'($urandom_range(3)) : rand_visits(), u,
                 $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom),
                 now, i == len - 1);
    end
  endtask

  initial begin
    int items;
    sb = new();
    rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0;
    in_gain_fixed = 0; in_visit_count = 0; in_updated_at = 0;
    in_decision_id = 0; in_now_step = 0; in_last_entry = 0;
    send_idle = 28; recv_idle = 86;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, ties, probation, single entry scans
    send_entry(24'sh7FFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0);
    send_entry(24'sh800000, 0, 0, 0, 0, 0);
    send_entry(0, 0, 0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0);
    send_entry(0, 0, 5, 7, 40, 0);
    send_entry(0, 0, 5, 8, 36, 1);
    send_entry(24'sh000001, 1, 100, 1, 100, 1);
    send_entry(24'sh010000, 3, 10, 2, 9, 0);
    send_entry(24'sh010000, 3, 10, 2, 41, 1);
    write_window(0);
    send_entry(5, 9, 100, 3, 100, 0);
    send_entry(5, 9, 99, 3, 100, 1);
    write_window(16'hFFFF);
    send_entry(-1, 2, 48'hFFFF_FFFF_0000, 4, 48'hFFFF_FFFF_FFFE, 0);
    send_entry(7, 1, 0, 4, 48'hFFFF_FFFF_FFFF, 1);
    write_window(1);
    send_entry(3, 4, 50, 1, 50, 0);
    send_entry(3, 4, 50, 1, 51, 1);
    // long scan past the entry limit
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 300; i++)
      send_entry(GAIN_W'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                 {$urandom, $urandom}, i == 299);
    write_window(32);

    items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 28 : ph == 1 ? 86 : 0;
      recv_idle = ph == 0 ? 86 : ph == 1 ? 28 : 0;
      for (int k = 0; k < 40; k++) begin
        int len;
        len = $urandom_range(7) == 0 ? $urandom_range(60, 256) : $urandom_range(1, 8);
        if (ph == 2 && k == 10) drain();
        random_scan(len);
        items += len;
        if (items > 420 * (ph + 1)) break;
      end
      write_window(ph == 0 ? 16'd3 : ph == 1 ? 16'hFFFF : 16'd32);
    end

    drain();
    if (sb.mismatches == 0 && sb.victims.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
